@@ src/spe_pkg.sv @@
// Package for the shifted-pattern pursuit encoder: sizes, register indexes,
// opcodes and the command and status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package spe_pkg;

    localparam int MAX_PATTERNS    = 8;
    localparam int MAX_PATTERN_LEN = 32;
    localparam int MAX_CHANNELS    = 8;
    localparam int MAX_TRACE_LEN   = 256;
    localparam int MAX_EVENTS      = 16;

    localparam int STORE_DEPTH = 2048;
    localparam int ADDR_W      = 11;

    typedef logic [2:0]  t_cfg_idx;
    typedef logic [31:0] t_cfg_data;

    localparam t_cfg_idx REG_NUM_PATTERNS = 3'd0;
    localparam t_cfg_idx REG_PATTERN_LEN  = 3'd1;
    localparam t_cfg_idx REG_NUM_CHANNELS = 3'd2;
    localparam t_cfg_idx REG_TRACE_LEN    = 3'd3;
    localparam t_cfg_idx REG_REFRACTORY   = 3'd4;
    localparam t_cfg_idx REG_MAX_EVENTS   = 3'd5;
    localparam t_cfg_idx REG_AMP_FLOOR    = 3'd6;

    localparam logic [1:0] OP_LOAD_PATTERN = 2'd0;
    localparam logic [1:0] OP_LOAD_TRACE   = 2'd1;
    localparam logic [1:0] OP_RUN          = 2'd2;

    typedef struct packed {
        logic load;
        logic copy_start;
        logic copy;
        logic srch_init;
        logic chk_rd;
        logic adv;
        logic mac_start;
        logic mac_issue;
        logic cmp_adv;
        logic take;
        logic sub_start;
        logic sub_issue;
        logic blk_start;
        logic blk_wr;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic copy_done;
        logic nof_zero;
        logic blocked;
        logic scan_last;
        logic m_last;
        logic pipe_busy;
        logic stop;
        logic pend_v;
        logic out_busy;
        logic blk_done;
        logic ev_done;
    } t_sts;

endpackage

`default_nettype wire

@@ src/spe_in_if.sv @@
// Request channel of the encoder: valid/ready plus one input item.
// No dependencies.
`default_nettype none

interface spe_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [10:0] element_index;
    logic signed [15:0] trace_sample;
    logic [15:0] pattern_weight;

    modport source(output valid, opcode, element_index, trace_sample, pattern_weight,
                   input ready);
    modport sink(input valid, opcode, element_index, trace_sample, pattern_weight,
                 output ready);
endinterface

`default_nettype wire

@@ src/spe_out_if.sv @@
// Result channel of the encoder: valid/ready plus one result item.
// No dependencies.
`default_nettype none

interface spe_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  pattern_id;
    logic [7:0]  delay;
    logic [31:0] amplitude;
    logic        found;
    logic        last;

    modport source(output valid, pattern_id, delay, amplitude, found, last, input ready);
    modport sink(input valid, pattern_id, delay, amplitude, found, last, output ready);
endinterface

`default_nettype wire

@@ src/spe_ctrl.sv @@
// Sequencer of the encoder: steps a run through copy, scan, decide,
// subtract and blocking phases. Depends on spe_pkg.
`default_nettype none

module spe_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic [1:0]   i_opcode,
    input  spe_pkg::t_sts i_sts,
    output spe_pkg::t_cmd o_cmd,
    output logic         o_ready
);
    import spe_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_COPY   = 4'd1;
    localparam logic [3:0] S_SRCH   = 4'd2;
    localparam logic [3:0] S_CHK    = 4'd3;
    localparam logic [3:0] S_CHKW   = 4'd4;
    localparam logic [3:0] S_MAC    = 4'd5;
    localparam logic [3:0] S_DRAIN  = 4'd6;
    localparam logic [3:0] S_CMP    = 4'd7;
    localparam logic [3:0] S_DECIDE = 4'd8;
    localparam logic [3:0] S_SUB    = 4'd9;
    localparam logic [3:0] S_SUBW   = 4'd10;
    localparam logic [3:0] S_BLK    = 4'd11;
    localparam logic [3:0] S_FIN    = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == OP_RUN) begin
                        o_cmd.copy_start = 1'b1;
                        n_state = S_COPY;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_COPY: begin
                if (i_sts.copy_done) n_state = S_SRCH;
                else o_cmd.copy = 1'b1;
            end
            S_SRCH: begin
                o_cmd.srch_init = 1'b1;
                n_state = i_sts.nof_zero ? S_DECIDE : S_CHK;
            end
            S_CHK: begin
                o_cmd.chk_rd = 1'b1;
                n_state = S_CHKW;
            end
            S_CHKW: begin
                if (i_sts.blocked) begin
                    o_cmd.adv = 1'b1;
                    n_state = i_sts.scan_last ? S_DECIDE : S_CHK;
                end else begin
                    o_cmd.mac_start = 1'b1;
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                o_cmd.mac_issue = 1'b1;
                if (i_sts.m_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp_adv = 1'b1;
                n_state = i_sts.scan_last ? S_DECIDE : S_CHK;
            end
            S_DECIDE: begin
                if (i_sts.stop) begin
                    n_state = S_FIN;
                end else if (!(i_sts.pend_v && i_sts.out_busy)) begin
                    o_cmd.take      = 1'b1;
                    o_cmd.sub_start = 1'b1;
                    n_state = S_SUB;
                end
            end
            S_SUB: begin
                o_cmd.sub_issue = 1'b1;
                if (i_sts.m_last) n_state = S_SUBW;
            end
            S_SUBW: begin
                if (!i_sts.pipe_busy) begin
                    o_cmd.blk_start = 1'b1;
                    n_state = S_BLK;
                end
            end
            S_BLK: begin
                if (!i_sts.blk_done) o_cmd.blk_wr = 1'b1;
                else n_state = i_sts.ev_done ? S_FIN : S_SRCH;
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

endmodule

`default_nettype wire

@@ src/spe_dp.sv @@
// Datapath of the encoder: configuration registers, pattern, trace, residual
// and blocked-offset memories, the multiply-accumulate pipeline and the
// result registers. Depends on spe_pkg.
`default_nettype none

module spe_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  spe_pkg::t_cmd        i_cmd,
    output spe_pkg::t_sts        o_sts,
    input  logic                 i_cfg_we,
    input  spe_pkg::t_cfg_idx    i_cfg_idx,
    input  spe_pkg::t_cfg_data   i_cfg_data,
    input  logic [1:0]           i_opcode,
    input  logic [10:0]          i_element_index,
    input  logic signed [15:0]   i_trace_sample,
    input  logic [15:0]          i_pattern_weight,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [2:0]           o_pattern_id,
    output logic [7:0]           o_delay,
    output logic [31:0]          o_amplitude,
    output logic                 o_found,
    output logic                 o_last
);
    import spe_pkg::*;

    localparam logic signed [34:0] RES_HI = 35'sd8388607;
    localparam logic signed [34:0] RES_LO = -35'sd8388608;

    // Configuration.
    logic [3:0]  r_np;
    logic [5:0]  r_pl;
    logic [3:0]  r_nc;
    logic [8:0]  r_tl;
    logic [8:0]  r_span;
    logic [4:0]  r_ev;
    logic [31:0] r_floor;

    logic [3:0] np_c;
    logic [5:0] pl_c;
    logic [3:0] nc_c;
    logic [8:0] tl_c;
    logic [4:0] ev_c;
    logic [8:0] m_tot;
    logic [8:0] nof;

    // Memories.
    logic [15:0]        pat_mem [STORE_DEPTH];
    logic [15:0]        trc_mem [STORE_DEPTH];
    logic signed [23:0] res_mem [STORE_DEPTH];
    logic               blk_mem [STORE_DEPTH];

    // Sequencing counters.
    logic [11:0] r_n;
    logic        r_cv;
    logic [10:0] r_caddr;
    logic [15:0] r_trc_q;
    logic [2:0]  r_p;
    logic [7:0]  r_j;
    logic [10:0] r_rbase;
    logic [10:0] r_pbase;
    logic [7:0]  r_m;
    logic        r_blk_q;
    logic [8:0]  r_q;
    logic [9:0]  r_e;
    logic [4:0]  r_events;

    // Search result.
    logic signed [47:0] r_acc;
    logic signed [47:0] r_best;
    logic [2:0]  r_bp;
    logic [7:0]  r_bt;
    logic [10:0] r_brbase;
    logic [10:0] r_bpbase;
    logic [31:0] r_sub_amp;

    // Pipeline.
    logic        r_v1;
    logic        r_sub1;
    logic [10:0] r_addr1;
    logic signed [23:0] r_res_q;
    logic [15:0] r_pat_q;
    logic        r_v2;
    logic        r_sub2;
    logic [10:0] r_addr2;
    logic signed [23:0] r_res2;
    logic signed [40:0] r_mprod;
    logic [47:0] r_sprod;

    // Pending and output results.
    logic        r_pend_v;
    logic [2:0]  r_pend_pid;
    logic [7:0]  r_pend_dly;
    logic [31:0] r_pend_amp;
    logic        r_out_v;
    logic [2:0]  r_out_pid;
    logic [7:0]  r_out_dly;
    logic [31:0] r_out_amp;
    logic        r_out_found;
    logic        r_out_last;

    logic        issue;
    logic [10:0] rd_raddr;
    logic [10:0] rd_paddr;
    logic        j_last;
    logic [31:0] amp;
    logic [32:0] corr;
    logic signed [34:0] diff;
    logic signed [23:0] sat;
    logic [8:0]  blk_s;
    logic [9:0]  blk_e;
    logic [9:0]  bt_plus;

    always_comb begin
        np_c = (r_np == 4'd0) ? 4'd1 : ((r_np > 4'(MAX_PATTERNS)) ? 4'(MAX_PATTERNS) : r_np);
        pl_c = (r_pl == 6'd0) ? 6'd1
             : ((r_pl > 6'(MAX_PATTERN_LEN)) ? 6'(MAX_PATTERN_LEN) : r_pl);
        nc_c = (r_nc == 4'd0) ? 4'd1 : ((r_nc > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : r_nc);
        tl_c = (r_tl < 9'd2) ? 9'd2 : ((r_tl > 9'(MAX_TRACE_LEN)) ? 9'(MAX_TRACE_LEN) : r_tl);
        ev_c = (r_ev == 5'd0) ? 5'd1 : ((r_ev > 5'(MAX_EVENTS)) ? 5'(MAX_EVENTS) : r_ev);
        m_tot = {3'b0, pl_c} * {5'b0, nc_c};
        nof   = (tl_c > {3'b0, pl_c}) ? tl_c - {3'b0, pl_c} : 9'd0;
    end

    assign issue    = i_cmd.mac_issue | i_cmd.sub_issue;
    assign rd_raddr = (i_cmd.sub_issue ? r_brbase : r_rbase) + {3'b0, r_m};
    assign rd_paddr = (i_cmd.sub_issue ? r_bpbase : r_pbase) + {3'b0, r_m};
    assign j_last   = ({1'b0, r_j} == nof - 9'd1);
    assign amp      = r_best[47:16];

    // Rounded correction, then saturate the residual to 24 bits.
    assign corr = 33'((49'(r_sprod) + 49'd32768) >> 16);
    assign diff = $signed({{11{r_res2[23]}}, r_res2}) - $signed({2'b0, corr});
    always_comb begin
        if (diff > RES_HI) sat = RES_HI[23:0];
        else if (diff < RES_LO) sat = RES_LO[23:0];
        else sat = diff[23:0];
    end

    assign bt_plus = {2'b0, r_bt} + {1'b0, r_span};
    assign blk_s   = ({1'b0, r_bt} >= r_span) ? {1'b0, r_bt} - r_span : 9'd0;
    assign blk_e   = (bt_plus > {1'b0, tl_c}) ? {1'b0, tl_c} : bt_plus;

    always_comb begin
        o_sts           = '0;
        o_sts.copy_done = r_n[11] && !r_cv;
        o_sts.nof_zero  = (nof == 9'd0);
        o_sts.blocked   = r_blk_q;
        o_sts.scan_last = j_last && ({1'b0, r_p} == np_c - 4'd1);
        o_sts.m_last    = ({1'b0, r_m} == m_tot - 9'd1);
        o_sts.pipe_busy = r_v1 | r_v2 | r_cv;
        o_sts.stop      = (amp < r_floor);
        o_sts.pend_v    = r_pend_v;
        o_sts.out_busy  = r_out_v;
        o_sts.blk_done  = ({1'b0, r_q} >= r_e);
        o_sts.ev_done   = (r_events == ev_c);
    end

    // Memories.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_opcode == OP_LOAD_PATTERN) pat_mem[i_element_index] <= i_pattern_weight;
        if (issue) r_pat_q <= pat_mem[rd_paddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_opcode == OP_LOAD_TRACE) trc_mem[i_element_index] <= i_trace_sample;
        if (i_cmd.copy && !r_n[11]) r_trc_q <= trc_mem[r_n[10:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_cv) res_mem[r_caddr] <= {{8{r_trc_q[15]}}, r_trc_q};
        else if (r_v2 && r_sub2) res_mem[r_addr2] <= sat;
        if (issue) r_res_q <= res_mem[rd_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.copy && !r_n[11]) blk_mem[r_n[10:0]] <= 1'b0;
        else if (i_cmd.blk_wr) blk_mem[{r_bp, r_q[7:0]}] <= 1'b1;
        if (i_cmd.chk_rd) r_blk_q <= blk_mem[{r_p, r_j}];
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_caddr <= r_n[10:0];
        r_addr1 <= rd_raddr;
        r_addr2 <= r_addr1;
        r_res2  <= r_res_q;
        r_mprod <= 41'(r_res_q) * 41'($signed({1'b0, r_pat_q}));
        r_sprod <= 48'(r_sub_amp) * 48'(r_pat_q);
        if (i_cmd.mac_start) r_acc <= '0;
        else if (r_v2 && !r_sub2) r_acc <= r_acc + {{7{r_mprod[40]}}, r_mprod};
        if (i_cmd.blk_start) r_e <= blk_e;
        if (i_cmd.take) begin
            r_sub_amp  <= amp;
            r_pend_pid <= r_bp;
            r_pend_dly <= r_bt;
            r_pend_amp <= amp;
            if (r_pend_v) begin
                r_out_pid   <= r_pend_pid;
                r_out_dly   <= r_pend_dly;
                r_out_amp   <= r_pend_amp;
                r_out_found <= 1'b1;
                r_out_last  <= 1'b0;
            end
        end
        if (i_cmd.fin) begin
            r_out_pid   <= r_pend_v ? r_pend_pid : 3'd0;
            r_out_dly   <= r_pend_v ? r_pend_dly : 8'd0;
            r_out_amp   <= r_pend_v ? r_pend_amp : 32'd0;
            r_out_found <= r_pend_v;
            r_out_last  <= 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_np <= 4'd1; r_pl <= 6'd16; r_nc <= 4'd1; r_tl <= 9'd256;
            r_span <= 9'd0; r_ev <= 5'd16; r_floor <= 32'd4;
            r_n <= '0; r_cv <= 1'b0; r_p <= '0; r_j <= '0;
            r_rbase <= '0; r_pbase <= '0; r_m <= '0; r_q <= '0; r_events <= '0;
            r_best <= '0; r_bp <= '0; r_bt <= '0; r_brbase <= '0; r_bpbase <= '0;
            r_v1 <= 1'b0; r_sub1 <= 1'b0; r_v2 <= 1'b0; r_sub2 <= 1'b0;
            r_pend_v <= 1'b0; r_out_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_NUM_PATTERNS: r_np    <= i_cfg_data[3:0];
                    REG_PATTERN_LEN:  r_pl    <= i_cfg_data[5:0];
                    REG_NUM_CHANNELS: r_nc    <= i_cfg_data[3:0];
                    REG_TRACE_LEN:    r_tl    <= i_cfg_data[8:0];
                    REG_REFRACTORY:   r_span  <= i_cfg_data[8:0];
                    REG_MAX_EVENTS:   r_ev    <= i_cfg_data[4:0];
                    REG_AMP_FLOOR:    r_floor <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.copy_start) begin
                r_n <= '0;
                r_events <= '0;
                r_pend_v <= 1'b0;
            end else if (i_cmd.copy && !r_n[11]) begin
                r_n <= r_n + 12'd1;
            end
            r_cv <= i_cmd.copy && !r_n[11];

            r_v1   <= issue;
            r_sub1 <= i_cmd.sub_issue;
            r_v2   <= r_v1;
            r_sub2 <= r_sub1;

            if (i_cmd.mac_start || i_cmd.sub_start) r_m <= '0;
            else if (issue) r_m <= r_m + 8'd1;

            if (i_cmd.srch_init) begin
                r_p <= '0; r_j <= '0; r_rbase <= '0; r_pbase <= '0;
                r_best <= '0; r_bp <= '0; r_bt <= '0; r_brbase <= '0; r_bpbase <= '0;
            end else if (i_cmd.adv || i_cmd.cmp_adv) begin
                // A strictly larger score replaces the best; ties keep the earlier one.
                if (i_cmd.cmp_adv && r_acc > r_best) begin
                    r_best <= r_acc; r_bp <= r_p; r_bt <= r_j;
                    r_brbase <= r_rbase; r_bpbase <= r_pbase;
                end
                if (j_last) begin
                    r_j <= '0;
                    r_rbase <= '0;
                    r_p <= r_p + 3'd1;
                    r_pbase <= r_pbase + {2'b0, m_tot};
                end else begin
                    r_j <= r_j + 8'd1;
                    r_rbase <= r_rbase + {7'b0, nc_c};
                end
            end

            if (i_cmd.blk_start) r_q <= blk_s;
            else if (i_cmd.blk_wr) r_q <= r_q + 9'd1;

            if (i_out_ready && r_out_v) r_out_v <= 1'b0;
            if (i_cmd.take) begin
                r_events <= r_events + 5'd1;
                r_pend_v <= 1'b1;
                if (r_pend_v) r_out_v <= 1'b1;
            end
            if (i_cmd.fin) begin
                r_out_v  <= 1'b1;
                r_pend_v <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_pattern_id = r_out_pid;
    assign o_delay      = r_out_dly;
    assign o_amplitude  = r_out_amp;
    assign o_found      = r_out_found;
    assign o_last       = r_out_last;

    a_best_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_best[47]) else $error("best score went negative");

    a_res_write_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_cv && r_v2 && r_sub2)) else $error("copy and subtract write residual together");

    a_take_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take && r_pend_v) |-> !r_out_v) else $error("pending result overwrote output");

    a_fin_sets_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> (r_out_v && r_out_last)) else $error("run end without last result");

endmodule

`default_nettype wire

@@ src/shifted_pattern_pursuit_encoder_unit.sv @@
// Shifted-pattern pursuit encoder, usage notes.
// Request channel i_req: opcode 0 writes one pattern weight, opcode 1 one
// trajectory sample, both at element_index; opcode 2 runs a search. Opcode 3
// is dropped. Load requests are taken one per cycle and give no result.
// A run copies the trajectory into the residual and clears the blocked map in
// one pass over all 2048 entries, then for each activity scans every pattern
// and offset: each unblocked candidate goes through one multiply-accumulate
// pipeline, a blocked one only through its map check. A found activity adds
// a subtract pass through the same pipeline and one map write per blocked
// offset.
// Result channel o_res gives one result per activity, last set on the final
// one; an empty run gives one result with found clear. The last activity is
// held back until the run ends so that last is known. i_req.ready is high
// only between runs. A stalled receiver holds the output register and stops
// the run at its next result. Synchronous reset puts back the register
// defaults and idles the block; stores keep their contents.
// Depends on spe_pkg, spe_in_if, spe_out_if, spe_ctrl and spe_dp.
`default_nettype none

module shifted_pattern_pursuit_encoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    spe_in_if.sink             i_req,
    spe_out_if.source          o_res,
    input  logic               i_cfg_we,
    input  spe_pkg::t_cfg_idx  i_cfg_idx,
    input  spe_pkg::t_cfg_data i_cfg_data
);
    import spe_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic ready;

    assign i_req.ready = ready;

    spe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_opcode   (i_req.opcode),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_ready    (ready)
    );

    spe_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_opcode         (i_req.opcode),
        .i_element_index  (i_req.element_index),
        .i_trace_sample   (i_req.trace_sample),
        .i_pattern_weight (i_req.pattern_weight),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_pattern_id     (o_res.pattern_id),
        .o_delay          (o_res.delay),
        .o_amplitude      (o_res.amplitude),
        .o_found          (o_res.found),
        .o_last           (o_res.last)
    );

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for shifted_pattern_pursuit_encoder_unit: drives load
// and run requests with random bursts, predicts every activity, checks results.
// Depends on spe_pkg, spe_in_if, spe_out_if and the encoder RTL.
`timescale 1ns / 1ps

module tb;
    import spe_pkg::*;

    typedef struct {
        logic [1:0]  opcode;
        logic [10:0] element_index;
        logic [15:0] trace_sample;
        logic [15:0] pattern_weight;
    } req_item_t;

    typedef struct {
        logic [2:0]  pattern_id;
        logic [7:0]  delay;
        logic [31:0] amplitude;
        logic        found;
        logic        last;
    } activity_t;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Every run stays inside these store regions, which are written up front.
    localparam int FILL_PAT = 12;
    localparam int FILL_TRC = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    t_cfg_idx cfg_idx = '0;
    t_cfg_data cfg_data = '0;

    spe_in_if  req_if();
    spe_out_if res_if();

    shifted_pattern_pursuit_encoder_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Shadow copy of the block's state.
    logic [31:0] cfg_shadow [7];
    logic [15:0] weight_mem [STORE_DEPTH];
    logic [15:0] sample_mem [STORE_DEPTH];
    int          residual   [STORE_DEPTH];
    bit          blocked    [STORE_DEPTH];

    req_item_t pending_reqs[$];
    activity_t expected_acts[$];
    int mismatches = 0;
    int burst_left = 0;
    int gap_left = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int stall_phase = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.opcode = '0;
        req_if.element_index = '0;
        req_if.trace_sample = '0;
        req_if.pattern_weight = '0;
        res_if.ready = 1'b0;
    end

    function automatic int clamp_to(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // Greedy pursuit over the shadow stores; appends the expected activities.
    function automatic void pursue_activities();
        int np, pl, nc, tl, ev, nof, span, found_cnt, bp, bt, lo_off, hi_off, ri;
        longint best, acc, amp, prod, r;
        np = clamp_to(int'(cfg_shadow[REG_NUM_PATTERNS]), 1, MAX_PATTERNS);
        pl = clamp_to(int'(cfg_shadow[REG_PATTERN_LEN]), 1, MAX_PATTERN_LEN);
        nc = clamp_to(int'(cfg_shadow[REG_NUM_CHANNELS]), 1, MAX_CHANNELS);
        tl = clamp_to(int'(cfg_shadow[REG_TRACE_LEN]), 2, MAX_TRACE_LEN);
        ev = clamp_to(int'(cfg_shadow[REG_MAX_EVENTS]), 1, MAX_EVENTS);
        span = int'(cfg_shadow[REG_REFRACTORY]);
        nof = (tl > pl) ? tl - pl : 0;
        found_cnt = 0;
        for (int n = 0; n < STORE_DEPTH; n++) begin
            residual[n] = int'($signed(sample_mem[n]));
            blocked[n] = 1'b0;
        end
        for (int e = 0; e < ev; e++) begin
            best = 0;
            bp = 0;
            bt = 0;
            for (int p = 0; p < np; p++) begin
                for (int j = 0; j < nof; j++) begin
                    if (!blocked[p * MAX_TRACE_LEN + j]) begin
                        acc = 0;
                        for (int k = 0; k < pl; k++)
                            for (int l = 0; l < nc; l++)
                                acc += longint'(residual[(j + k) * nc + l]) *
                                       longint'(weight_mem[p * pl * nc + k * nc + l]);
                        if (acc > best) begin
                            best = acc;
                            bp = p;
                            bt = j;
                        end
                    end
                end
            end
            amp = best >>> 16;
            if (amp < longint'(cfg_shadow[REG_AMP_FLOOR]))
                break;
            expected_acts.push_back('{bp[2:0], bt[7:0], amp[31:0], 1'b1, 1'b0});
            found_cnt++;
            for (int k = 0; k < pl; k++) begin
                for (int l = 0; l < nc; l++) begin
                    ri = (bt + k) * nc + l;
                    prod = amp * longint'(weight_mem[bp * pl * nc + k * nc + l]);
                    r = longint'(residual[ri]) - ((prod + 32768) >>> 16);
                    if (r > 8388607) r = 8388607;
                    if (r < -8388608) r = -8388608;
                    residual[ri] = int'(r);
                end
            end
            lo_off = (bt - span < 0) ? 0 : bt - span;
            hi_off = (bt + span > tl) ? tl : bt + span;
            for (int q = lo_off; q < hi_off; q++)
                blocked[bp * MAX_TRACE_LEN + q] = 1'b1;
        end
        if (found_cnt == 0)
            expected_acts.push_back('{3'd0, 8'd0, 32'd0, 1'b0, 1'b0});
        expected_acts[$].last = 1'b1;
    endfunction

    function automatic void apply_request(req_item_t it);
        case (it.opcode)
            OP_LOAD_PATTERN: weight_mem[it.element_index] = it.pattern_weight;
            OP_LOAD_TRACE:   sample_mem[it.element_index] = it.trace_sample;
            OP_RUN:          pursue_activities();
            default: ;
        endcase
    endfunction

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge clk) begin
        req_item_t it;
        if (!rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (req_if.valid)
                apply_request('{req_if.opcode, req_if.element_index,
                                req_if.trace_sample, req_if.pattern_weight});
            if (gap_left > 0) begin
                gap_left--;
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                it = pending_reqs.pop_front();
                req_if.opcode <= it.opcode;
                req_if.element_index <= it.element_index;
                req_if.trace_sample <= it.trace_sample;
                req_if.pattern_weight <= it.pattern_weight;
                req_if.valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Result monitor with its own stall pattern, renewed after each pass through it.
    always @(posedge clk) begin
        activity_t want;
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_acts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: id=%0d delay=%0d amp=%0h found=%0b last=%0b",
                                 res_if.pattern_id, res_if.delay, res_if.amplitude,
                                 res_if.found, res_if.last);
                end else begin
                    want = expected_acts.pop_front();
                    if (res_if.pattern_id !== want.pattern_id || res_if.delay !== want.delay ||
                        res_if.amplitude !== want.amplitude || res_if.found !== want.found ||
                        res_if.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: exp id=%0d delay=%0d amp=%0h ",
                                     want.pattern_id, want.delay, want.amplitude,
                                     "found=%0b last=%0b, ", want.found, want.last,
                                     "got id=%0d delay=%0d amp=%0h ",
                                     res_if.pattern_id, res_if.delay, res_if.amplitude,
                                     "found=%0b last=%0b", res_if.found, res_if.last);
                    end
                end
            end
            if (stall_phase == 15)
                stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
            stall_phase = (stall_phase + 1) % 16;
            res_if.ready <= stall_pattern[stall_phase];
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] value);
        logic [31:0] mask;
        int widths [7] = '{4, 6, 4, 9, 9, 5, 32};
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        mask = (widths[idx] == 32) ? 32'hFFFF_FFFF : (32'd1 << widths[idx]) - 32'd1;
        cfg_shadow[idx] = value & mask;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(int np, int pl, int nc, int tl, int span, int ev,
                           logic [31:0] floor_val);
        write_reg(REG_NUM_PATTERNS, np);
        write_reg(REG_PATTERN_LEN, pl);
        write_reg(REG_NUM_CHANNELS, nc);
        write_reg(REG_TRACE_LEN, tl);
        write_reg(REG_REFRACTORY, span);
        write_reg(REG_MAX_EVENTS, ev);
        write_reg(REG_AMP_FLOOR, floor_val);
    endtask

    task automatic queue_req(logic [1:0] op, int idx, logic [15:0] smp, logic [15:0] wgt);
        pending_reqs.push_back('{op, idx[10:0], smp, wgt});
    endtask

    // Waits until every request is taken and every activity has come back.
    task automatic drain();
        while (pending_reqs.size() > 0 || req_if.valid || expected_acts.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // One random phase: small sizes, mostly loads into the region in use.
    task automatic random_phase();
        int np, pl, nc, tl, items;
        np = $urandom_range(1, 2);
        pl = $urandom_range(1, 3);
        nc = $urandom_range(1, 2);
        tl = $urandom_range(2, 10);
        set_all(np, pl, nc, tl, $urandom_range(0, 4), $urandom_range(1, 16),
                ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 64));
        items = $urandom_range(6, 12);
        for (int i = 0; i < items; i++) begin
            case ($urandom_range(0, 9))
                0: queue_req(OP_UNUSED, $urandom_range(0, 2047), 16'($urandom),
                             16'($urandom));
                1: queue_req(OP_LOAD_TRACE, $urandom_range(0, 2047), 16'($urandom),
                             16'($urandom));
                2, 3, 4: queue_req(OP_LOAD_PATTERN, $urandom_range(0, np * pl * nc - 1),
                                   16'($urandom), 16'($urandom));
                default: queue_req(OP_LOAD_TRACE, $urandom_range(0, tl * nc - 1),
                                   16'($urandom_range(0, 32767)), 16'($urandom));
            endcase
        end
        queue_req(OP_RUN, $urandom_range(0, 2047), 16'($urandom), 16'($urandom));
        drain();
    endtask

    initial begin
        cfg_shadow = '{32'd1, 32'd16, 32'd1, 32'd256, 32'd0, 32'd16, 32'd4};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Fill the regions in use so no run ever reads an unwritten entry.
        for (int n = 0; n < FILL_PAT; n++)
            queue_req(OP_LOAD_PATTERN, n, 16'($urandom), 16'($urandom));
        for (int n = 0; n < FILL_TRC; n++)
            queue_req(OP_LOAD_TRACE, n, 16'($urandom), 16'($urandom));
        drain();

        // Directed: field extremes, unknown opcode, then a normal run.
        set_all(2, 3, 2, 10, 1, 4, 4);
        queue_req(OP_LOAD_PATTERN, 0, 16'h0000, 16'hFFFF);
        queue_req(OP_LOAD_PATTERN, 1, 16'hFFFF, 16'h0000);
        queue_req(OP_LOAD_TRACE, 0, 16'h7FFF, 16'h0000);
        queue_req(OP_LOAD_TRACE, 1, 16'h8000, 16'hFFFF);
        queue_req(OP_LOAD_TRACE, 2047, 16'h8000, 16'hFFFF);
        queue_req(OP_UNUSED, 2047, 16'hFFFF, 16'hFFFF);
        queue_req(OP_RUN, 0, 16'h0, 16'h0);
        drain();

        // Empty run: an all-negative trace yields no positive peak.
        for (int n = 0; n < FILL_TRC; n++)
            queue_req(OP_LOAD_TRACE, n, 16'h8000 | 16'($urandom), 16'h0);
        queue_req(OP_RUN, 0, 16'h0, 16'h0);
        drain();

        // Zero floor: zero peaks are still reported, span zero blocks nothing.
        set_all(2, 3, 2, 10, 0, 3, 0);
        queue_req(OP_RUN, 0, 16'h0, 16'h0);
        drain();

        // No candidate offset: pattern as long as the trace.
        set_all(1, 4, 1, 4, 3, 2, 0);
        queue_req(OP_RUN, 0, 16'h0, 16'h0);
        drain();

        // Registers below their ranges are clamped up.
        set_all(0, 0, 0, 0, 0, 0, 1);
        queue_req(OP_RUN, 0, 16'h0, 16'h0);
        drain();

        // Largest event count and refractory span, with an unreachable floor too.
        set_all(3, 2, 2, 10, 511, 31, 0);
        queue_req(OP_RUN, 0, 16'h0, 16'h0);
        drain();
        write_reg(REG_REFRACTORY, 256);
        write_reg(REG_AMP_FLOOR, 32'hFFFF_FFFF);
        queue_req(OP_RUN, 0, 16'h0, 16'h0);
        drain();

        // Pattern and event counts clamped from above, inside the filled region.
        set_all(15, 1, 1, 12, 2, 31, 0);
        queue_req(OP_RUN, 0, 16'h0, 16'h0);
        drain();

        for (int ph = 0; ph < 4; ph++)
            random_phase();

        if (mismatches == 0 && expected_acts.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("tb failed");
        $finish;
    end

endmodule
